// File: design/lppr_pkg.sv
// lppr_pkg: shared types and constants for the pose-registered lidar point filter
// no dependencies
`default_nettype none
package lppr_pkg;
  localparam logic [1:0] CMD_ODOM  = 2'd0;
  localparam logic [1:0] CMD_CLOUD = 2'd1;
  localparam logic [1:0] CMD_POINT = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_OVH    = 3'd1;
  localparam logic [2:0] REG_CULLEN = 3'd2;
  localparam logic [2:0] REG_CULL   = 3'd3;
  localparam logic [2:0] REG_BLANK  = 3'd4;
  localparam logic [2:0] REG_WIN    = 3'd5;

  localparam logic [47:0] ONE_SECOND_US = 48'd1000000;
  localparam logic signed [17:0] Q16_ONE = 18'sd65536;
  localparam logic [62:0] DR2_MAX = {63{1'b1}};

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE, OP_WRITE, OP_SCAN, OP_PICK, OP_NUM, OP_DIV, OP_POINT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       scan_first;
    logic [3:0] rot_idx;
  } lppr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic pt_busy;
  } lppr_stat_t;
endpackage
`default_nettype wire

// File: design/lppr_ctrl.sv
// lppr_ctrl: sequencer for odometry writes, history scan, rotation build and points
// depends on lppr_pkg
`default_nettype none
module lppr_ctrl
  import lppr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] cmd_i,
  output logic            in_stall_o,
  input  wire logic       out_busy_i,
  input  lppr_stat_t      stat_i,
  output lppr_cmd_t       cmd_o
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_NUM, S_DIV} state_e;
  state_e state_q;
  logic [3:0] idx_q;
  logic first_q;
  logic take;

  // points wait while an earlier point is in the pipe or held at the output
  always_comb begin
    in_stall_o = (state_q != S_IDLE) ||
                 ((out_busy_i || stat_i.pt_busy) && cmd_i == CMD_POINT);
  end
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o = '{op: OP_NONE, scan_first: first_q, rot_idx: idx_q};
    case (state_q)
      S_IDLE: begin
        if (take && cmd_i == CMD_ODOM) cmd_o.op = OP_WRITE;
        else if (take && cmd_i == CMD_POINT) cmd_o.op = OP_POINT;
        else if (take && cmd_i == CMD_CLOUD) begin
          cmd_o.op = OP_SCAN;
          cmd_o.scan_first = 1'b1;
        end
      end
      S_SCAN: cmd_o.op = OP_SCAN;
      S_PICK: cmd_o.op = OP_PICK;
      S_NUM:  cmd_o.op = OP_NUM;
      S_DIV:  cmd_o.op = OP_DIV;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      first_q <= 1'b0;
    end else begin
      first_q <= 1'b0;
      case (state_q)
        S_IDLE: if (take && cmd_i == CMD_CLOUD) state_q <= S_SCAN;
        S_SCAN: if (stat_i.scan_done) state_q <= S_PICK;
        S_PICK: begin
          idx_q <= '0;
          state_q <= S_NUM;
        end
        S_NUM: state_q <= S_DIV;
        S_DIV: if (stat_i.div_done) begin
          if (idx_q == 4'd8) state_q <= S_IDLE;
          else begin
            idx_q <= idx_q + 4'd1;
            state_q <= S_NUM;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && stat_i.div_done && idx_q == 4'd8 |=> state_q == S_IDLE)
    else $error("rotation build did not finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("input taken during cloud start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd8)
    else $error("rotation index out of range");
endmodule
`default_nettype wire

// File: design/lppr_dp.sv
// lppr_dp: pose history memory, scan, serial divider, point transform and tests
// depends on lppr_pkg
`default_nettype none
module lppr_dp
  import lppr_pkg::*;
#(
  parameter int unsigned Depth = 50
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  lppr_cmd_t               cmd_i,
  output lppr_stat_t              stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [62:0]        cfg_data_i,
  input  wire logic [47:0]        stamp_us_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic               not_a_number_i,
  input  wire logic               last_point_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic                    keep_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic                    out_last_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);

  // configuration
  logic mode_q, cullen_q;
  logic [30:0] ovh_q;
  logic [62:0] cull_q, blank_q;
  logic [19:0] win_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1; ovh_q <= 31'd6553600; cullen_q <= 1'b0;
      cull_q <= 63'd42949672960000; blank_q <= '0; win_q <= 20'd20000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q <= cfg_data_i[0];
        REG_OVH:    ovh_q <= cfg_data_i[30:0];
        REG_CULLEN: cullen_q <= cfg_data_i[0];
        REG_CULL:   cull_q <= cfg_data_i;
        REG_BLANK:  blank_q <= cfg_data_i;
        REG_WIN:    win_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // history memory: stamp, position, quaternion per entry
  typedef struct packed {
    logic [47:0] stamp;
    logic signed [31:0] px, py, pz;
    logic [63:0] quat;
  } entry_t;
  entry_t mem [Depth];
  entry_t rd_q;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] count_q;
  logic [AW-1:0] oldest_q, wr_addr, sum_addr;
  logic odom_q;
  logic signed [31:0] latest_z_q;
  logic [CW:0] sum;

  assign sum = (CW+1)'(oldest_q) + (CW+1)'(count_q);
  assign sum_addr = (sum >= (CW+1)'(Depth)) ? AW'(sum - (CW+1)'(Depth)) : AW'(sum);
  assign wr_addr = (count_q < CW'(Depth)) ? sum_addr : oldest_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE)
      mem[wr_addr] <= '{stamp_us_i, coord_x_i, coord_y_i, coord_z_i,
                        {quat_w_i, quat_z_i, quat_y_i, quat_x_i}};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; oldest_q <= '0; odom_q <= 1'b0; latest_z_q <= '0;
    end else if (cmd_i.op == OP_WRITE) begin
      odom_q <= 1'b1;
      latest_z_q <= coord_z_i;
      if (count_q < CW'(Depth)) count_q <= count_q + CW'(1);
      else oldest_q <= (oldest_q == LAST) ? '0 : oldest_q + AW'(1);
    end
  end

  // scan: issue reads oldest first, compare each entry in the cycle after its read
  // the picked entry is read during the last scan cycle
  logic [CW-1:0] n_q;
  logic [AW-1:0] ptr_q, pick_q, cmp_addr_q;
  logic cmp_v_q, found_q;
  logic [47:0] cstamp_q, best_q, gap;
  assign rd_addr = (cmd_i.op == OP_SCAN && cmd_i.scan_first) ? oldest_q :
                   (stat_o.scan_done || cmd_i.op == OP_PICK) ? pick_q : ptr_q;
  assign gap = (rd_q.stamp > cstamp_q) ? rd_q.stamp - cstamp_q : cstamp_q - rd_q.stamp;
  assign stat_o.scan_done = (cmd_i.op == OP_SCAN) && !cmd_i.scan_first &&
                            (n_q == '0) && !cmp_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; cmp_v_q <= 1'b0; found_q <= 1'b0;
    end else if (cmd_i.op == OP_SCAN) begin
      if (cmd_i.scan_first) begin
        cstamp_q <= stamp_us_i;
        best_q <= ONE_SECOND_US;
        found_q <= 1'b0;
        cmp_v_q <= (count_q != '0);
        n_q <= (count_q != '0) ? count_q - CW'(1) : '0;
        cmp_addr_q <= oldest_q;
        ptr_q <= (oldest_q == LAST) ? '0 : oldest_q + AW'(1);
      end else begin
        if (cmp_v_q && gap < best_q) begin
          best_q <= gap; pick_q <= cmp_addr_q; found_q <= 1'b1;
        end
        cmp_v_q <= (n_q != '0);
        if (n_q != '0) begin
          n_q <= n_q - CW'(1);
          cmp_addr_q <= ptr_q;
          ptr_q <= (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
        end
      end
    end
  end

  // chosen pose and rotation build
  logic signed [31:0] cpos_q [3];
  logic signed [17:0] rot_q [9];
  logic ok_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [33:0] d_q;
  logic signed [33:0] d_sum;
  logic signed [33:0] num;
  logic [51:0] rem_q, mag_q;
  logic [50:0] quo_q;
  logic [5:0] bit_q;
  logic neg_q, dz_q;
  logic signed [31:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  assign xx = qx_q * qx_q; assign yy = qy_q * qy_q;
  assign zz = qz_q * qz_q; assign ww = qw_q * qw_q;
  assign xy = qx_q * qy_q; assign xz = qx_q * qz_q; assign yz = qy_q * qz_q;
  assign wx = qw_q * qx_q; assign wy = qw_q * qy_q; assign wz = qw_q * qz_q;
  assign d_sum = 34'(xx) + 34'(yy) + 34'(zz) + 34'(ww);

  always_comb begin
    case (cmd_i.rot_idx)
      4'd0: num = d_sum - 34'sd2 * (34'(yy) + 34'(zz));
      4'd1: num = 34'sd2 * (34'(xy) - 34'(wz));
      4'd2: num = 34'sd2 * (34'(xz) + 34'(wy));
      4'd3: num = 34'sd2 * (34'(xy) + 34'(wz));
      4'd4: num = d_sum - 34'sd2 * (34'(xx) + 34'(zz));
      4'd5: num = 34'sd2 * (34'(yz) - 34'(wx));
      4'd6: num = 34'sd2 * (34'(xz) - 34'(wy));
      4'd7: num = 34'sd2 * (34'(yz) + 34'(wx));
      default: num = d_sum - 34'sd2 * (34'(xx) + 34'(yy));
    endcase
  end

  // restoring divider: (2|n|*65536 + d) / (2d), one quotient bit per cycle
  logic [52:0] trial;
  logic [51:0] den2;
  logic [50:0] qfin;
  logic signed [51:0] sq;
  assign den2 = {17'd0, d_q[33:0], 1'b0};
  assign trial = {rem_q, mag_q[51]} - {1'b0, den2};
  assign qfin = {quo_q[49:0], ~trial[52]};
  assign sq = neg_q ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
  assign stat_o.div_done = (cmd_i.op == OP_DIV) && (dz_q || bit_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) cpos_q[i] <= '0;
      for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? Q16_ONE : '0;
      ok_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_PICK: begin
          cpos_q[0] <= found_q ? rd_q.px : '0;
          cpos_q[1] <= found_q ? rd_q.py : '0;
          cpos_q[2] <= found_q ? rd_q.pz : '0;
          qx_q <= found_q ? rd_q.quat[15:0] : '0;
          qy_q <= found_q ? rd_q.quat[31:16] : '0;
          qz_q <= found_q ? rd_q.quat[47:32] : '0;
          qw_q <= found_q ? rd_q.quat[63:48] : '0;
          ok_q <= mode_q ? odom_q : (odom_q && found_q && best_q < {28'd0, win_q});
        end
        OP_NUM: begin
          d_q <= d_sum;
          dz_q <= (xx == 0) && (yy == 0) && (zz == 0) && (ww == 0);
          neg_q <= num[33];
          mag_q <= {1'b0, (num[33] ? 34'(-num) : num), 17'd0} + {18'd0, d_sum};
          rem_q <= '0; quo_q <= '0; bit_q <= 6'd51;
        end
        OP_DIV: begin
          if (dz_q) rot_q[cmd_i.rot_idx] <= (cmd_i.rot_idx % 4 == 0) ? Q16_ONE : '0;
          else if (bit_q == '0)
            rot_q[cmd_i.rot_idx] <= (sq > 52'sd131071) ? 18'sd131071 :
                                    (sq < -52'sd131072) ? -18'sd131072 : 18'(sq);
          else begin
            rem_q <= trial[52] ? {rem_q[50:0], mag_q[51]} : trial[51:0];
            quo_q <= qfin;
            mag_q <= {mag_q[50:0], 1'b0};
            bit_q <= bit_q - 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // point path: stage 1 products, then sums that feed stage 2
  logic pv_q, pv2_q, nan_q, last_q, zero_q, mode_p_q;
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic signed [49:0] prod_q [9];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else pv_q <= (cmd_i.op == OP_POINT);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_POINT) begin
      vx_q <= coord_x_i; vy_q <= coord_y_i; vz_q <= coord_z_i;
      nan_q <= not_a_number_i; last_q <= last_point_i; mode_p_q <= mode_q;
      zero_q <= mode_q ? (coord_x_i == 0 && coord_y_i == 0)
                       : (coord_x_i == 0 || coord_y_i == 0);
      for (int r = 0; r < 3; r++) begin
        prod_q[3*r]   <= rot_q[3*r]   * coord_x_i;
        prod_q[3*r+1] <= rot_q[3*r+1] * coord_y_i;
        prod_q[3*r+2] <= rot_q[3*r+2] * coord_z_i;
      end
    end
  end

  logic signed [51:0] s [3];
  logic [51:0] mg [3];
  logic signed [52:0] t [3];
  logic signed [31:0] p [3];
  logic signed [31:0] pt_q [3];
  logic ok2_q, last2_q;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s[r] = 52'(prod_q[3*r]) + 52'(prod_q[3*r+1]) + 52'(prod_q[3*r+2]);
      mg[r] = s[r][51] ? 52'(-s[r]) : 52'(s[r]);
      mg[r] = (mg[r] + 52'd32768) >> 16;
      t[r] = (s[r][51] ? -$signed({1'b0, mg[r]}) : $signed({1'b0, mg[r]})) + 53'(cpos_q[r]);
      p[r] = (t[r] > 53'sd2147483647) ? 32'sh7fffffff :
             (t[r] < -53'sd2147483648) ? 32'sh80000000 : 32'(t[r]);
    end
    if (mode_p_q) begin p[0] = vx_q; p[1] = vy_q; p[2] = vz_q; end
  end

  // stage 2: squares, stage 3 accumulation and tests
  logic [65:0] sqv [3];
  logic [63:0] sqs_q [3];
  logic signed [32:0] dz_diff_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv2_q <= 1'b0;
    else pv2_q <= pv_q;
  end
  assign stat_o.pt_busy = pv_q || pv2_q;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic signed [32:0] dl;
      dl = 33'(cpos_q[r]) - 33'(p[r]);
      sqv[r] = 66'(dl) * 66'(dl);
    end
  end
  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      for (int r = 0; r < 3; r++) begin
        sqs_q[r] <= (sqv[r] > 66'(DR2_MAX)) ? {1'b0, DR2_MAX} : sqv[r][63:0];
        pt_q[r] <= p[r];
      end
      dz_diff_q <= 33'(p[2]) - 33'(latest_z_q);
      ok2_q <= !zero_q && ok_q && !nan_q;
      last2_q <= last_q;
    end
  end

  logic [64:0] a1, a2;
  logic [62:0] dr2;
  assign a1 = 65'(sqs_q[0]) + 65'(sqs_q[1]);
  assign a2 = ((a1 > 65'(DR2_MAX)) ? 65'(DR2_MAX) : a1) + 65'(sqs_q[2]);
  assign dr2 = (a2 > 65'(DR2_MAX)) ? DR2_MAX : a2[62:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (pv2_q) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (pv2_q) begin
      keep_o <= ok2_q && (dz_diff_q < $signed({2'b0, ovh_q})) &&
                (!cullen_q || dr2 < cull_q) && (dr2 > blank_q);
      out_x_o <= pt_q[0]; out_y_o <= pt_q[1]; out_z_o <= pt_q[2];
      out_last_o <= last2_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("history count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_WRITE |=> odom_q)
    else $error("odometry flag not set");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !pv2_q |=> $stable(out_x_o))
    else $error("held result changed");
endmodule
`default_nettype wire

// File: design/lidar_point_pose_register_filter_core.sv
// lidar_point_pose_register_filter_core: top level, controller plus datapath
// depends on lppr_pkg, lppr_ctrl, lppr_dp
// a point item gives its result after the product, square and output registers; a point waits
// while an earlier point is in the pipe or held, so a new point is taken only once the last has left
// the pipe; an odometry item is a single history write; a cloud start scans the history and
// then builds the nine rotation elements one by one in the shared serial divider; no other
// item is taken meanwhile
// reset clears control, config to defaults, identity rotation; history needs no clearing
`default_nettype none
module lidar_point_pose_register_filter_core
  import lppr_pkg::*;
#(
  parameter int unsigned HistoryDepth = 50
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [62:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [47:0]        stamp_us_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic               not_a_number_i,
  input  wire logic               last_point_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    keep_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic                    out_last_o
);
  lppr_cmd_t  cmd;
  lppr_stat_t stat;
  logic busy;

  // a held result at the output: together with the points in flight, stalls new points so the pipe cannot overrun
  assign busy = out_valid_o && out_stall_i;

  lppr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .cmd_i, .in_stall_o,
    .out_busy_i(busy), .stat_i(stat), .cmd_o(cmd)
  );

  lppr_dp #(.Depth(HistoryDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .stamp_us_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .not_a_number_i, .last_point_i, .out_stall_i, .out_valid_o,
    .keep_o, .out_x_o, .out_y_o, .out_z_o, .out_last_o
  );
endmodule
`default_nettype wire
